// ===== rtl/sampled_input_debouncer_defines.svh =====
// ----------------------------------------------------------------------------
// sampled_input_debouncer_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLED_INPUT_DEBOUNCER_DEFINES_SVH
`define SAMPLED_INPUT_DEBOUNCER_DEFINES_SVH

// same-cycle implication
`define SID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_pkg: debouncer types and constants
// Item, result, configuration and state records plus code constants.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // edge kinds asked for by a take
  localparam logic KIND_FALL = 1'b0;
  localparam logic KIND_RISE = 1'b1;

  // latched edge codes
  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;
  localparam logic [1:0] EDGE_RISE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 2'd3;

  // reset values
  localparam logic [CNT_W-1:0] RST_SAMPLE_PERIOD = 16'd10;
  localparam logic [CNT_W-1:0] RST_HIGH_COUNT    = 16'd3;
  localparam logic [CNT_W-1:0] RST_LOW_COUNT     = 16'd3;
  localparam logic             RST_LEVEL         = 1'b1;
  localparam logic [CNT_W-1:0] START_COUNTDOWN   = 16'd100;

  typedef struct packed {
    logic op;
    logic pin_level;
    logic edge_kind;
    logic query_level;
  } item_t;

  typedef struct packed {
    logic              level;
    logic [1:0]        pending_edge;
    logic              edge_taken;
    logic [TIME_W-1:0] time_in_level;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] sample_period;
    logic [CNT_W-1:0] high_count;
    logic [CNT_W-1:0] low_count;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [CNT_W-1:0]  countdown;
    logic [CNT_W-1:0]  high_run;
    logic [CNT_W-1:0]  low_run;
    logic              level;
    logic [1:0]        latched_edge;
    logic [TIME_W-1:0] high_stamp;
    logic [TIME_W-1:0] low_stamp;
  } state_t;

endpackage

// ===== rtl/sid_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_if: debouncer channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sid_in_if;
  logic valid;
  logic ready;
  logic op;
  logic pin_level;
  logic edge_kind;
  logic query_level;

  modport source (output valid, output op, output pin_level, output edge_kind,
                  output query_level, input ready);
  modport sink (input valid, input op, input pin_level, input edge_kind,
                input query_level, output ready);
endinterface

interface sid_out_if;
  logic        valid;
  logic        ready;
  logic        level;
  logic [1:0]  pending_edge;
  logic        edge_taken;
  logic [31:0] time_in_level;

  modport source (output valid, output level, output pending_edge, output edge_taken,
                  output time_in_level, input ready);
  modport sink (input valid, input level, input pending_edge, input edge_taken,
                input time_in_level, output ready);
endinterface

// ===== rtl/sid_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_step: one-item update of the debouncer
// Next state and result for a tick or a take, from current state and config.
// ----------------------------------------------------------------------------
module sid_step (
  input  sid_pkg::state_t  state_i,
  input  sid_pkg::cfg_t    cfg_i,
  input  sid_pkg::item_t   item_i,
  output sid_pkg::state_t  state_o,
  output sid_pkg::result_t result_o
);

  logic [sid_pkg::CNT_W:0] run_hi;
  logic [sid_pkg::CNT_W:0] run_lo;
  logic                    sample;
  logic [1:0]              want;
  logic                    taken;
  logic [sid_pkg::TIME_W-1:0] stamp;

  assign run_hi = {1'b0, state_i.high_run} + 17'd1;
  assign run_lo = {1'b0, state_i.low_run} + 17'd1;
  assign sample = (item_i.op == sid_pkg::OP_TICK) && (state_i.countdown <= 16'd1);
  assign want   = (item_i.edge_kind == sid_pkg::KIND_RISE) ? sid_pkg::EDGE_RISE
                                                           : sid_pkg::EDGE_FALL;

  always_comb begin
    state_o = state_i;
    taken   = 1'b0;
    if (item_i.op == sid_pkg::OP_TICK) begin
      state_o.now_ms = state_i.now_ms + 32'd1;
      if (sample) begin
        state_o.countdown = cfg_i.sample_period;
        if (item_i.pin_level) begin
          if (run_hi == {1'b0, cfg_i.high_count}) begin
            if (!state_i.level) state_o.latched_edge = sid_pkg::EDGE_RISE;
            state_o.level      = 1'b1;
            state_o.high_stamp = state_o.now_ms;
          end
          if (run_hi >= {1'b0, cfg_i.high_count}) begin
            state_o.low_run  = '0;
            state_o.high_run = cfg_i.high_count;
          end else begin
            state_o.high_run = run_hi[sid_pkg::CNT_W-1:0];
          end
        end else begin
          if (run_lo == {1'b0, cfg_i.low_count}) begin
            if (state_i.level) state_o.latched_edge = sid_pkg::EDGE_FALL;
            state_o.level     = 1'b0;
            state_o.low_stamp = state_o.now_ms;
          end
          if (run_lo >= {1'b0, cfg_i.low_count}) begin
            state_o.high_run = '0;
            state_o.low_run  = cfg_i.low_count;
          end else begin
            state_o.low_run = run_lo[sid_pkg::CNT_W-1:0];
          end
        end
      end else begin
        state_o.countdown = state_i.countdown - 16'd1;
      end
    end else if (state_i.latched_edge == want) begin
      state_o.latched_edge = sid_pkg::EDGE_NONE;
      taken                = 1'b1;
    end
  end

  assign stamp = state_o.level ? state_o.high_stamp : state_o.low_stamp;

  always_comb begin
    result_o.level         = state_o.level;
    result_o.pending_edge  = state_o.latched_edge;
    result_o.edge_taken    = taken;
    result_o.time_in_level = (item_i.query_level == state_o.level)
                             ? state_o.now_ms - stamp : '0;
  end

endmodule

// ===== rtl/sampled_input_debouncer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_input_debouncer: counter debounce with edge latch
// Debounces one pin on millisecond ticks, latches edges, reports level time.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake          payload
// -------  ---  -----------------  ----------------------------------------
// in_ch    in   valid/ready        op, pin_level, edge_kind, query_level
// out_ch   out  valid/ready        level, pending_edge, edge_taken,
//                                  time_in_level
// cfg_*    in   cfg_we, no wait    cfg_index (2b), cfg_data (16b)
//
// Throughput: one item per clock while out_ch.ready holds; each item passes the input
//   register, then the update logic writes state and the result register together.
// The state update is one short cone (16-bit compares, 32-bit increment and
//   subtract), so an item may use the state left by the one just before it.
// Reset: synchronous, active low; state and config to their defaults,
//   countdown to 100, level high, no edge latched.
// Stalls: a held result blocks the update stage only; one more item waits
//   in the input register, after which in_ch.ready drops.
//
`include "sampled_input_debouncer_defines.svh"

module sampled_input_debouncer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sid_pkg::CNT_W-1:0]        cfg_data,
  sid_in_if.sink                           in_ch,
  sid_out_if.source                        out_ch
);

  // configuration
  sid_pkg::cfg_t   cfg_r;
  logic            init_level_r;

  // debouncer state
  sid_pkg::state_t state_r;
  sid_pkg::state_t state_nxt;

  // input register
  logic            s1_valid_r;
  sid_pkg::item_t  s1_item_r;

  // result register
  logic             out_valid_r;
  sid_pkg::result_t out_res_r;
  sid_pkg::result_t res_nxt;

  logic fire;

  // update stage moves when the result slot is free or being emptied
  assign fire         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || fire;

  sid_step u_step (
    .state_i  (state_r),
    .cfg_i    (cfg_r),
    .item_i   (s1_item_r),
    .state_o  (state_nxt),
    .result_o (res_nxt)
  );

  // control, state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      cfg_r.sample_period   <= sid_pkg::RST_SAMPLE_PERIOD;
      cfg_r.high_count      <= sid_pkg::RST_HIGH_COUNT;
      cfg_r.low_count       <= sid_pkg::RST_LOW_COUNT;
      init_level_r          <= sid_pkg::RST_LEVEL;
      state_r.now_ms        <= '0;
      state_r.countdown     <= sid_pkg::START_COUNTDOWN;
      state_r.high_run      <= '0;
      state_r.low_run       <= '0;
      state_r.level         <= sid_pkg::RST_LEVEL;
      state_r.latched_edge  <= sid_pkg::EDGE_NONE;
      state_r.high_stamp    <= '0;
      state_r.low_stamp     <= '0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (fire) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // the user must keep writes to idle times, unchecked by the block; the period write reloads the countdown
      if (cfg_we) begin
        unique case (cfg_index)
          sid_pkg::REG_SAMPLE_PERIOD: begin
            cfg_r.sample_period <= cfg_data;
            state_r.countdown   <= cfg_data;
          end
          sid_pkg::REG_HIGH_COUNT: begin
            cfg_r.high_count <= cfg_data;
          end
          sid_pkg::REG_LOW_COUNT: begin
            cfg_r.low_count <= cfg_data;
          end
          sid_pkg::REG_INITIAL_LEVEL: begin
            init_level_r  <= cfg_data[0];
            state_r.level <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_item_r.op          <= in_ch.op;
      s1_item_r.pin_level   <= in_ch.pin_level;
      s1_item_r.edge_kind   <= in_ch.edge_kind;
      s1_item_r.query_level <= in_ch.query_level;
    end
    if (fire) out_res_r <= res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.level         = out_res_r.level;
  assign out_ch.pending_edge  = out_res_r.pending_edge;
  assign out_ch.edge_taken    = out_res_r.edge_taken;
  assign out_ch.time_in_level = out_res_r.time_in_level;

  // init_level_r holds the last written assumed level; it has no reader
  // beyond this check, which ties a fresh write to the debounced level.
  `SID_ASSERT_NEXT(a_init_sets_level, cfg_we && (cfg_index == sid_pkg::REG_INITIAL_LEVEL), state_r.level == init_level_r, "initial_level write did not set level")

  `SID_ASSERT_IMPL(a_edge_code, 1'b1, state_r.latched_edge != 2'd3, "latched edge holds an unused code")

  `SID_ASSERT_IMPL(a_taken_clears, out_valid_r && out_res_r.edge_taken, out_res_r.pending_edge == sid_pkg::EDGE_NONE, "taken edge still pending")

  `SID_ASSERT_NEXT(a_tick_advances, fire && (s1_item_r.op == sid_pkg::OP_TICK) && !cfg_we, state_r.now_ms == $past(state_r.now_ms) + 32'd1, "tick did not advance time")

  `SID_ASSERT_IMPL(a_empty_ready, !s1_valid_r, in_ch.ready, "empty input register not ready")

endmodule
